// ----- src/dlsv_pkg.sv -----
// Shared types and constants for the display-list stream validator.
// No dependencies; imported by dlsv_judge and the top level.
`timescale 1ns / 1ps

package dlsv_pkg;

   // First-error codes, as reported on the result beat
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_HEADER  = 3'd1,
      ERR_PAYLOAD = 3'd2,
      ERR_SIZE    = 3'd3,
      ERR_ART     = 3'd4,
      ERR_TEXT    = 3'd5
   } err_type;

   // Opcodes with special handling
   localparam logic [15:0] OPC_ART  = 16'd23;
   localparam logic [15:0] OPC_ICON = 16'd24;

   // Header is four bytes: opcode low/high, length low/high
   localparam logic [1:0] HDR_LAST = 2'd3;

   // Art definition: inner length sits at payload bytes 4 and 5
   localparam logic [15:0] INNER_LO_INDEX   = 16'd4;
   localparam logic [15:0] INNER_HI_INDEX   = 16'd5;
   localparam logic [15:0] ART_MIN_LENGTH   = 16'd7;
   localparam logic [15:0] ART_HEADER_BYTES = 16'd6;

endpackage

// ----- src/display_list_stream_validator.sv -----
// Display-list stream validator: one byte per beat, one result beat per list.
// A result is registered: the beat marked last passes the beat register and then loads the result register.
// Throughput: one input beat per cycle; the beat register feeds the parse
// state directly, and only a last beat waits while an untaken result is held.
// Reset (synchronous, active high) clears parse state, counters and both valids.
`timescale 1ns / 1ps

module display_list_stream_validator
   import dlsv_pkg::*;
#(
   parameter int COUNT_BITS  = 16,
   parameter int LENGTH_BITS = 24
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_carries_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_list_ok,
   output logic [2:0]             rsp_error_code,
   output logic [COUNT_BITS-1:0]  rsp_command_total,
   output logic [COUNT_BITS-1:0]  rsp_icon_total,
   output logic [LENGTH_BITS-1:0] rsp_bytes_read
);

   // Beat register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_carries_ff;
   logic       s1_last_ff;

   // Parse state
   logic                   in_payload_ff, in_payload_in;
   logic [1:0]             header_index_ff, header_index_in;
   logic [15:0]            opcode_ff, opcode_in;
   logic [15:0]            length_ff, length_in;
   logic [15:0]            payload_index_ff, payload_index_in;
   logic [15:0]            inner_ff, inner_in;
   err_type                error_ff, error_in;
   logic [COUNT_BITS-1:0]  cmd_cnt_ff, cmd_cnt_in;
   logic [COUNT_BITS-1:0]  icon_cnt_ff, icon_cnt_in;
   logic [LENGTH_BITS-1:0] byte_cnt_ff, byte_cnt_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   err_type                rsp_err_ff, rsp_err_in;
   logic [COUNT_BITS-1:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [COUNT_BITS-1:0]  rsp_icon_ff, rsp_icon_in;
   logic [LENGTH_BITS-1:0] rsp_bytes_ff, rsp_bytes_in;

   logic        s1_hold, s1_fire, s1_fire_last, take;
   logic [15:0] hdr_length, inner_next;
   logic [15:0] judge_length, judge_inner;
   logic [7:0]  judge_final;
   logic        payload_end, complete;
   err_type     judge_err, final_err;

   // Only a last beat needs the result register free
   assign s1_hold      = s1_last_ff && rsp_valid_ff && rsp_stall;
   assign s1_fire      = s1_valid_ff && !s1_hold;
   assign s1_fire_last = s1_fire && s1_last_ff;
   assign req_stall    = s1_valid_ff && s1_hold;
   assign take         = s1_fire && s1_carries_ff && (error_ff == ERR_NONE);

   // Assemble the completed length and the art inner length
   assign hdr_length = {s1_byte_ff, length_ff[7:0]};
   always_comb begin
      inner_next = inner_ff;
      if (payload_index_ff == INNER_LO_INDEX) begin
         inner_next = {8'd0, s1_byte_ff};
      end else if (payload_index_ff == INNER_HI_INDEX) begin
         inner_next = {s1_byte_ff, inner_ff[7:0]};
      end
   end

   assign payload_end  = ({1'b0, payload_index_ff} + 17'd1) >= {1'b0, length_ff};
   assign complete     = take && (in_payload_ff ? payload_end
                                  : (header_index_ff == HDR_LAST && hdr_length == 16'd0));
   assign judge_length = in_payload_ff ? length_ff  : hdr_length;
   assign judge_inner  = in_payload_ff ? inner_next : 16'd0;
   assign judge_final  = in_payload_ff ? s1_byte_ff : 8'd0;

   dlsv_judge u_judge (
      .opcode     (opcode_ff),
      .length     (judge_length),
      .inner      (judge_inner),
      .final_byte (judge_final),
      .err        (judge_err)
   );

   // Advance parse state and counters for the beat in the register
   always_comb begin
      in_payload_in    = in_payload_ff;
      header_index_in  = header_index_ff;
      opcode_in        = opcode_ff;
      length_in        = length_ff;
      payload_index_in = payload_index_ff;
      inner_in         = inner_ff;
      error_in         = error_ff;
      cmd_cnt_in       = cmd_cnt_ff;
      icon_cnt_in      = icon_cnt_ff;
      byte_cnt_in      = byte_cnt_ff;

      if (s1_fire && s1_carries_ff && byte_cnt_ff != {LENGTH_BITS{1'b1}}) begin
         byte_cnt_in = byte_cnt_ff + LENGTH_BITS'(1);
      end

      if (take) begin
         if (!in_payload_ff) begin
            header_index_in = header_index_ff + 2'd1;
            unique case (header_index_ff)
               2'd0: opcode_in = {8'd0, s1_byte_ff};
               2'd1: opcode_in = {s1_byte_ff, opcode_ff[7:0]};
               2'd2: length_in = {8'd0, s1_byte_ff};
               default: begin
                  length_in        = hdr_length;
                  payload_index_in = 16'd0;
                  inner_in         = 16'd0;
                  in_payload_in    = (hdr_length != 16'd0);
               end
            endcase
         end else begin
            inner_in = inner_next;
            if (payload_end) begin
               in_payload_in = 1'b0;
            end else begin
               payload_index_in = payload_index_ff + 16'd1;
            end
         end
      end

      // Record the first error or count the command
      if (complete) begin
         if (judge_err != ERR_NONE) begin
            error_in = judge_err;
         end else begin
            if (cmd_cnt_ff != {COUNT_BITS{1'b1}}) begin
               cmd_cnt_in = cmd_cnt_ff + COUNT_BITS'(1);
            end
            if (opcode_ff == OPC_ICON && icon_cnt_ff != {COUNT_BITS{1'b1}}) begin
               icon_cnt_in = icon_cnt_ff + COUNT_BITS'(1);
            end
         end
      end

      // End of list: flag an unfinished command
      final_err = error_in;
      if (error_in == ERR_NONE) begin
         if (in_payload_in) begin
            final_err = ERR_PAYLOAD;
         end else if (header_index_in != 2'd0) begin
            final_err = ERR_HEADER;
         end
      end

      rsp_ok_in    = (final_err == ERR_NONE);
      rsp_err_in   = final_err;
      rsp_cmd_in   = cmd_cnt_in;
      rsp_icon_in  = icon_cnt_in;
      rsp_bytes_in = byte_cnt_in;

      // Clear everything for the next list
      if (s1_fire_last) begin
         in_payload_in    = 1'b0;
         header_index_in  = 2'd0;
         opcode_in        = 16'd0;
         length_in        = 16'd0;
         payload_index_in = 16'd0;
         inner_in         = 16'd0;
         error_in         = ERR_NONE;
         cmd_cnt_in       = '0;
         icon_cnt_in      = '0;
         byte_cnt_in      = '0;
      end
   end

   // Beat register takes a new beat whenever it is not held
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   // Result register: load on a last beat, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         in_payload_ff    <= 1'b0;
         header_index_ff  <= 2'd0;
         opcode_ff        <= 16'd0;
         length_ff        <= 16'd0;
         payload_index_ff <= 16'd0;
         inner_ff         <= 16'd0;
         error_ff         <= ERR_NONE;
         cmd_cnt_ff       <= '0;
         icon_cnt_ff      <= '0;
         byte_cnt_ff      <= '0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         in_payload_ff    <= in_payload_in;
         header_index_ff  <= header_index_in;
         opcode_ff        <= opcode_in;
         length_ff        <= length_in;
         payload_index_ff <= payload_index_in;
         inner_ff         <= inner_in;
         error_ff         <= error_in;
         cmd_cnt_ff       <= cmd_cnt_in;
         icon_cnt_ff      <= icon_cnt_in;
         byte_cnt_ff      <= byte_cnt_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_byte_ff    <= req_byte_value;
         s1_carries_ff <= req_carries_byte;
         s1_last_ff    <= req_last_byte;
      end
      if (s1_fire_last) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_err_ff   <= rsp_err_in;
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_icon_ff  <= rsp_icon_in;
         rsp_bytes_ff <= rsp_bytes_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_list_ok       = rsp_ok_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_command_total = rsp_cmd_ff;
   assign rsp_icon_total    = rsp_icon_ff;
   assign rsp_bytes_read    = rsp_bytes_ff;

`ifndef SYNTHESIS
   // A new result only follows a last beat leaving the beat register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire_last))
      else $error("result raised without a last beat");

   // Verdict agrees with the reported error
   a_ok_matches_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_err_ff == ERR_NONE)))
      else $error("list_ok disagrees with error_code");

   // First error sticks until the end of the list
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (error_ff != ERR_NONE && !s1_fire_last) |=> $stable(error_ff))
      else $error("first error changed mid-list");

   // Header position is idle while inside a payload
   a_payload_header: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (header_index_ff == 2'd0))
      else $error("header index moved inside a payload");
`endif

endmodule

// ----- src/dlsv_judge.sv -----
// Command checker: fixed size, art inner length and text rules for one command.
// Depends on dlsv_pkg.
`timescale 1ns / 1ps

module dlsv_judge
   import dlsv_pkg::*;
(
   input  logic [15:0] opcode,
   input  logic [15:0] length,
   input  logic [15:0] inner,
   input  logic [7:0]  final_byte,
   output err_type     err
);

   logic       size_known;
   logic [4:0] size_want;
   logic       text_known;
   logic [3:0] text_min;

   // Look up the fixed payload size of known opcodes
   always_comb begin
      size_known = 1'b1;
      size_want  = 5'd0;
      unique case (opcode)
         16'd1, 16'd2, 16'd18:   size_want = 5'd12;
         16'd3:                  size_want = 5'd16;
         16'd4, 16'd5:           size_want = 5'd10;
         16'd8, 16'd16, 16'd17:  size_want = 5'd8;
         16'd24:                 size_want = 5'd16;
         16'd25:                 size_want = 5'd10;
         16'd28, 16'd29:         size_want = 5'd14;
         16'd30:                 size_want = 5'd6;
         16'd9:                  size_want = 5'd0;
         default:                size_known = 1'b0;
      endcase
   end

   // Look up the minimum length of text-carrying opcodes
   always_comb begin
      text_known = 1'b1;
      text_min   = 4'd0;
      unique case (opcode)
         16'd6:  text_min = 4'd10;
         16'd7:  text_min = 4'd14;
         16'd19, 16'd20, 16'd21, 16'd22, 16'd26, 16'd27, 16'd31, 16'd32:
            text_min = 4'd13;
         default: text_known = 1'b0;
      endcase
   end

   // Apply checks in order: size, art, text
   always_comb begin
      err = ERR_NONE;
      priority if (size_known && length != {11'd0, size_want}) begin
         err = ERR_SIZE;
      end else if (opcode == OPC_ART &&
                   (length < ART_MIN_LENGTH || inner != length - ART_HEADER_BYTES)) begin
         err = ERR_ART;
      end else if (text_known &&
                   (length < {12'd0, text_min} || final_byte != 8'd0)) begin
         err = ERR_TEXT;
      end else begin
         err = ERR_NONE;
      end
   end

endmodule
